// ===== rtl/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the text tokenizer
// Result kinds, tokenizer modes, register indexes and the result record.
// ----------------------------------------------------------------------------
package ctt_pkg;

  typedef enum logic [2:0] {
    KIND_TBYTE = 3'd0,
    KIND_TEND  = 3'd1,
    KIND_DELIM = 3'd2,
    KIND_CBYTE = 3'd3,
    KIND_CEND  = 3'd4,
    KIND_QERR  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_BARE    = 2'd1,
    MODE_QUOTED  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_SKIP   = 3'd0,
    REG_SINGLE = 3'd1,
    REG_QUOTE  = 3'd2,
    REG_OPEN   = 3'd3,
    REG_CLOSE  = 3'd4,
    REG_ENABLE = 3'd5,
    REG_KEEP   = 3'd6
  } reg_idx_t;

  localparam int unsigned NUM_SETS   = 5;
  localparam int unsigned SET_SKIP   = 0;
  localparam int unsigned SET_SINGLE = 1;
  localparam int unsigned SET_QUOTE  = 2;
  localparam int unsigned SET_OPEN   = 3;
  localparam int unsigned SET_CLOSE  = 4;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       quoted;
    logic       last;
  } result_t;

endpackage

// ===== rtl/configurable_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// configurable_text_tokenizer_unit: delimiter, quote and comment tokenizer
// Classifies one byte per beat against five configurable character sets and
// emits token, delimiter and comment results through a small result queue.
// ----------------------------------------------------------------------------
// Each input beat writes its results into the result queue, which offers them in order.
// Throughput: one input beat per cycle while results drain at one per cycle;
// a beat with two results takes two queue entries, and the input
// stalls while fewer than two of the four result queue entries are free.
// Reset (synchronous, rst high): the tokenizer state, the queue and all
// configuration registers clear at once; no clearing pass is needed.
module configurable_text_tokenizer_unit #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned SET_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        stream_end,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  out_byte,
  output logic        quoted,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ctt_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

  // configuration registers
  logic [63:0] skip_set, single_set, quote_set, open_set, close_set;
  logic [39:0] slot_enables;
  logic        keep_comments;

  // tokenizer state
  mode_t               mode, mode_next;
  logic [DEPTH_W-1:0]  comment_depth, comment_depth_next;
  logic [7:0]          open_quote, open_quote_next;
  logic                token_nonempty, token_nonempty_next;
  logic                quote_seen, quote_seen_next;

  // result queue
  result_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   rd_ptr, wr_ptr;
  logic [FIFO_CW-1:0]   count, count_next;

  logic        accept, pop;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic [NUM_SETS-1:0] hit;
  logic [63:0] set_val [NUM_SETS];
  result_t     res0, res1;
  logic [1:0]  res_cnt;
  logic        dec_zero;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_set      <= '0;
      single_set    <= '0;
      quote_set     <= '0;
      open_set      <= '0;
      close_set     <= '0;
      slot_enables  <= '0;
      keep_comments <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SKIP:   skip_set      <= pwdata;
        REG_SINGLE: single_set    <= pwdata;
        REG_QUOTE:  quote_set     <= pwdata;
        REG_OPEN:   open_set      <= pwdata;
        REG_CLOSE:  close_set     <= pwdata;
        REG_ENABLE: slot_enables  <= pwdata[39:0];
        REG_KEEP:   keep_comments <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SKIP:   prdata = skip_set;
      REG_SINGLE: prdata = single_set;
      REG_QUOTE:  prdata = quote_set;
      REG_OPEN:   prdata = open_set;
      REG_CLOSE:  prdata = close_set;
      REG_ENABLE: prdata = {24'd0, slot_enables};
      REG_KEEP:   prdata = {63'd0, keep_comments};
      default:    prdata = '0;
    endcase
  end

  // Set membership: every enabled slot is compared in parallel.
  assign set_val[SET_SKIP]   = skip_set;
  assign set_val[SET_SINGLE] = single_set;
  assign set_val[SET_QUOTE]  = quote_set;
  assign set_val[SET_OPEN]   = open_set;
  assign set_val[SET_CLOSE]  = close_set;

  always_comb begin
    hit = '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int i = 0; i < SET_SLOTS; i++) begin
        if (slot_enables[8*s+i] && (set_val[s][8*i +: 8] == in_byte)) begin
          hit[s] = 1'b1;
        end
      end
    end
  end

  assign dec_zero = (comment_depth <= DEPTH_W'(1));

  // Next state of the tokenizer for the current input beat.
  always_comb begin
    mode_next           = mode;
    comment_depth_next  = comment_depth;
    open_quote_next     = open_quote;
    token_nonempty_next = token_nonempty;
    quote_seen_next     = quote_seen;
    if (stream_end) begin
      mode_next           = MODE_BETWEEN;
      comment_depth_next  = '0;
      open_quote_next     = '0;
      token_nonempty_next = 1'b0;
      quote_seen_next     = 1'b0;
    end else begin
      case (mode)
        MODE_BARE: begin
          if (hit[SET_SKIP] || hit[SET_SINGLE]) begin
            token_nonempty_next = 1'b0;
            mode_next           = MODE_BETWEEN;
          end else if (hit[SET_OPEN]) begin
            mode_next          = MODE_COMMENT;
            comment_depth_next = DEPTH_W'(1);
          end else begin
            token_nonempty_next = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (quote_seen) begin
            quote_seen_next = 1'b0;
            if (in_byte != open_quote) begin
              // Closing quote confirmed: this byte is classified as if between tokens.
              open_quote_next     = '0;
              token_nonempty_next = 1'b0;
              if (hit[SET_SKIP] || hit[SET_SINGLE]) begin
                mode_next = MODE_BETWEEN;
              end else if (hit[SET_QUOTE]) begin
                open_quote_next = in_byte;
              end else if (hit[SET_OPEN]) begin
                mode_next          = MODE_COMMENT;
                comment_depth_next = DEPTH_W'(1);
              end else begin
                mode_next           = MODE_BARE;
                token_nonempty_next = 1'b1;
              end
            end
          end else if (in_byte == open_quote) begin
            quote_seen_next = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (hit[SET_CLOSE]) begin
            if (comment_depth != '0) begin
              comment_depth_next = comment_depth - DEPTH_W'(1);
            end
            if (dec_zero) begin
              mode_next = MODE_BARE;
            end
          end else if (hit[SET_OPEN]) begin
            if (comment_depth < DEPTH_W'(MAX_DEPTH)) begin
              comment_depth_next = comment_depth + DEPTH_W'(1);
            end
          end
        end
        default: begin
          token_nonempty_next = 1'b0;
          if (hit[SET_SKIP] || hit[SET_SINGLE]) begin
            mode_next = MODE_BETWEEN;
          end else if (hit[SET_QUOTE]) begin
            mode_next       = MODE_QUOTED;
            open_quote_next = in_byte;
            quote_seen_next = 1'b0;
          end else if (hit[SET_OPEN]) begin
            mode_next          = MODE_COMMENT;
            comment_depth_next = DEPTH_W'(1);
          end else begin
            mode_next           = MODE_BARE;
            token_nonempty_next = 1'b1;
          end
        end
      endcase
    end
  end

  // Results of the current input beat, at most two, in order.
  always_comb begin
    res0    = '{kind: KIND_TBYTE, data: 8'd0, quoted: 1'b0, last: 1'b0};
    res1    = '{kind: KIND_TBYTE, data: 8'd0, quoted: 1'b0, last: 1'b0};
    res_cnt = 2'd0;
    if (stream_end) begin
      case (mode)
        MODE_BARE: begin
          if (token_nonempty) begin
            res0.kind = KIND_TEND;
            res_cnt   = 2'd1;
          end
        end
        MODE_QUOTED: begin
          if (quote_seen) begin
            res0.kind   = KIND_TEND;
            res0.quoted = 1'b1;
          end else begin
            res0.kind = KIND_QERR;
          end
          res_cnt = 2'd1;
        end
        MODE_COMMENT: begin
          if (keep_comments) begin
            res0.kind = KIND_CEND;
            res1.kind = KIND_TEND;
            res_cnt   = token_nonempty ? 2'd2 : 2'd1;
          end else if (token_nonempty) begin
            res0.kind = KIND_TEND;
            res_cnt   = 2'd1;
          end
        end
        default: ;
      endcase
    end else begin
      case (mode)
        MODE_BARE: begin
          if (hit[SET_SKIP]) begin
            res0.kind = KIND_TEND;
            res_cnt   = token_nonempty ? 2'd1 : 2'd0;
          end else if (hit[SET_SINGLE]) begin
            if (token_nonempty) begin
              res0.kind = KIND_TEND;
              res1.kind = KIND_DELIM;
              res1.data = in_byte;
              res_cnt   = 2'd2;
            end else begin
              res0.kind = KIND_DELIM;
              res0.data = in_byte;
              res_cnt   = 2'd1;
            end
          end else if (!hit[SET_OPEN]) begin
            res0.kind = KIND_TBYTE;
            res0.data = in_byte;
            res_cnt   = 2'd1;
          end
        end
        MODE_QUOTED: begin
          if (quote_seen && (in_byte != open_quote)) begin
            res0.kind   = KIND_TEND;
            res0.quoted = 1'b1;
            res_cnt     = 2'd1;
            if (hit[SET_SKIP]) begin
              res_cnt = 2'd1;
            end else if (hit[SET_SINGLE]) begin
              res1.kind = KIND_DELIM;
              res1.data = in_byte;
              res_cnt   = 2'd2;
            end else if (!hit[SET_QUOTE] && !hit[SET_OPEN]) begin
              res1.kind = KIND_TBYTE;
              res1.data = in_byte;
              res_cnt   = 2'd2;
            end
          end else if (quote_seen || (in_byte != open_quote)) begin
            // Either a doubled quote or an ordinary byte inside the quotes.
            res0.kind   = KIND_TBYTE;
            res0.data   = in_byte;
            res0.quoted = 1'b1;
            res_cnt     = 2'd1;
          end
        end
        MODE_COMMENT: begin
          if (hit[SET_CLOSE]) begin
            if (dec_zero && keep_comments) begin
              res0.kind = KIND_CEND;
              res_cnt   = 2'd1;
            end
          end else if (!hit[SET_OPEN] && keep_comments) begin
            res0.kind = KIND_CBYTE;
            res0.data = in_byte;
            res_cnt   = 2'd1;
          end
        end
        default: begin
          if (hit[SET_SINGLE] && !hit[SET_SKIP]) begin
            res0.kind = KIND_DELIM;
            res0.data = in_byte;
            res_cnt   = 2'd1;
          end else if (!hit[SET_SKIP] && !hit[SET_QUOTE] && !hit[SET_OPEN]) begin
            res0.kind = KIND_TBYTE;
            res0.data = in_byte;
            res_cnt   = 2'd1;
          end
        end
      endcase
    end
    if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  assign in_ready = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BETWEEN;
      comment_depth  <= '0;
      open_quote     <= '0;
      token_nonempty <= 1'b0;
      quote_seen     <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      comment_depth  <= comment_depth_next;
      open_quote     <= open_quote_next;
      token_nonempty <= token_nonempty_next;
      quote_seen     <= quote_seen_next;
    end
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = count_next + FIFO_CW'(res_cnt);
    end
    if (pop) begin
      count_next = count_next - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (accept) begin
        wr_ptr <= wr_ptr + FIFO_AW'(res_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (res_cnt != 2'd0)) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (accept && (res_cnt == 2'd2)) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= res1;
    end
  end

  assign kind     = fifo_mem[rd_ptr].kind;
  assign out_byte = fifo_mem[rd_ptr].data;
  assign quoted   = fifo_mem[rd_ptr].quoted;
  assign last     = fifo_mem[rd_ptr].last;

endmodule

// ===== rtl/ctt_checker.sv =====
// ----------------------------------------------------------------------------
// ctt_checker: port-level checks of the text tokenizer
// Watches the result channel for reset behavior and consistent result beats.
// ----------------------------------------------------------------------------
module ctt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] out_byte,
  input logic       quoted,
  input logic       last
);
  import ctt_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // Ends and errors carry no character.
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_TEND || kind == KIND_CEND || kind == KIND_QERR)
    |-> out_byte == 8'd0)
    else $error("end or error result carries a character");

  // An open quote error is always the only result of its beat.
  a_qerr_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_QERR |-> last && !quoted)
    else $error("open quote error not a lone unquoted result");

  // Delimiters and comment results never belong to a quoted token.
  a_unquoted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DELIM || kind == KIND_CBYTE || kind == KIND_CEND)
    |-> !quoted)
    else $error("delimiter or comment result marked quoted");

endmodule

bind configurable_text_tokenizer_unit ctt_checker u_ctt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_byte  (out_byte),
  .quoted    (quoted),
  .last      (last)
);
